// ----- hw/rtl/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg - shared types and constants of the priority tone sequencer
// Request and result layouts, action codes, controller states and the
// fixed widths of the tone divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Note store geometry
  localparam int unsigned NoteDepth = 64;
  localparam int unsigned AddrW     = $clog2(NoteDepth);

  // Timer clock and tone divider widths
  localparam int unsigned TimerClockHz = 240000000;
  localparam int unsigned QuotW        = 28;
  localparam int unsigned RemW         = 33;
  localparam int unsigned CntW         = $clog2(QuotW);

  // Action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_PLAY  = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [7:0] PRIO_IDLE = 8'd255;

  typedef struct packed {
    logic [1:0]       action;
    logic [AddrW-1:0] note_addr;
    logic [15:0]      note_freq;
    logic [15:0]      note_duration;
    logic [AddrW-1:0] seq_start;
    logic [7:0]       seq_length;
    logic             loop_mode;
    logic [7:0]       priority_req;
  } pts_in_t;

  typedef struct packed {
    logic [27:0] reload_value;
    logic [26:0] compare_value;
    logic        tone_update;
    logic        active;
    logic [7:0]  note_position;
  } pts_out_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] duration;
  } pts_note_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } pts_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/pts_note_mem.sv -----
// ----------------------------------------------------------------------------
// pts_note_mem - note store
// One write port and one registered read port holding frequency and
// duration pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_note_mem
  import pts_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire pts_note_t        wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output pts_note_t             rdata_o
);

  pts_note_t mem_q [NoteDepth];
  pts_note_t rdata_q;

  // Write a note entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/pts_tone_div.sv -----
// ----------------------------------------------------------------------------
// pts_tone_div - bit-serial tone divider
// Divides the timer clock by frequency times (prescaler plus one), one
// quotient bit per cycle, and returns the PWM reload and compare values.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_tone_div
  import pts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] freq_i,
  input  wire logic [15:0] prescale_i,
  output logic             done_o,
  output logic [27:0]      reload_o,
  output logic [26:0]      compare_o
);

  logic [RemW-1:0]  divisor_q;
  logic [RemW-1:0]  rem_q;
  logic [QuotW-1:0] shift_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [RemW-1:0]  product;
  logic [RemW-1:0]  rem_shift;
  logic             rem_geq;
  logic [QuotW-1:0] period;

  // Form the divisor
  assign product = {17'd0, freq_i} * {16'd0, ({1'b0, prescale_i} + 17'd1)};

  // Bring in the next dividend bit and trial-subtract
  assign rem_shift = {rem_q[RemW-2:0], shift_q[QuotW-1]};
  assign rem_geq   = (rem_shift >= divisor_q);

  // Advance one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(QuotW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Hold the operands and the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= product;
      rem_q     <= '0;
      shift_q   <= QuotW'(TimerClockHz);
    end else if (busy_q) begin
      rem_q   <= rem_geq ? (rem_shift - divisor_q) : rem_shift;
      shift_q <= {shift_q[QuotW-2:0], rem_geq};
    end
  end

  // Drop the quotient by one, clamped at zero
  assign period    = (shift_q == '0) ? '0 : (shift_q - 1'b1);
  assign reload_o  = period;
  assign compare_o = period[27:1];
  assign done_o    = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/priority_tone_sequencer.sv -----
// ----------------------------------------------------------------------------
// priority_tone_sequencer - buzzer tone sequence player with priorities
// Loads notes into a store, takes play requests filtered by priority and
// steps through the sequence on millisecond ticks, programming PWM values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request
//   per item: a tick, a note write or a play request. Every request yields
//   exactly one result on the output channel (out_valid_o / out_stall_i /
//   out_data_o), in order.
//   The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets
//   the timer prescaler; write it only while the block is idle.
//   Processing: a write, play, unused action or idle tick goes straight to
//   the result; a tick that reads one note and sounds no new tone passes
//   one note store read; a tick that steps to a silent note passes two.
//   A starting tick with a sounding first note and a tick that steps to a
//   sounding note also wait for the bit-serial divider, which forms 28
//   quotient bits and then hands over its result, behind one or two note
//   store reads. One request is in flight at a time; in_stall_o is high
//   until its result has been placed in the output register, so no new
//   request is taken before the result of the last one has been loaded.
//   Reset clears the sequence state, writes silence and sets priority 255;
//   the note store holds no defined contents until written.
//   A stalled receiver holds the result in the output register; the next
//   request is processed meanwhile and waits before its result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_tone_sequencer
  import pts_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pts_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pts_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  pts_state_e state_q, state_d;

  logic [15:0]      prescale_q;
  logic             has_seq_q;
  logic             playing_q;
  logic [AddrW-1:0] start_q;
  logic [7:0]       length_q;
  logic             loop_q;
  logic [7:0]       prio_q;
  logic [7:0]       index_q;
  logic [15:0]      elapsed_q;
  logic [27:0]      reload_q;
  logic [26:0]      compare_q;
  logic             update_q;
  logic [AddrW-1:0] rd_addr_q;
  logic             rd_freq_q;
  logic             out_valid_q;
  pts_out_t         out_data_q;

  logic             accept;
  logic             out_free;
  logic             mem_we;
  logic             div_start;
  logic             out_load;
  logic             play_ignore;
  logic             dur_hit;
  logic             seq_end;
  logic             freq_zero;
  logic [7:0]       index_next;
  pts_note_t        note_wdata;
  pts_note_t        note_rdata;
  logic             div_done;
  logic [27:0]      div_reload;
  logic [26:0]      div_compare;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // Decode the conditions of the current request
  assign play_ignore = (in_data_i.seq_length == 8'd0)
                    || (has_seq_q && playing_q && (start_q == in_data_i.seq_start))
                    || (has_seq_q && (in_data_i.priority_req > prio_q));
  assign index_next  = index_q + 8'd1;
  assign dur_hit     = (elapsed_q >= note_rdata.duration);
  assign seq_end     = (index_next >= length_q);
  assign freq_zero   = (note_rdata.freq == 16'd0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_data_i.action == ACT_TICK) && has_seq_q) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (rd_freq_q) begin
          state_d = freq_zero ? ST_DONE : ST_DIV;
        end else if (dur_hit && !seq_end) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_we     = accept && (in_data_i.action == ACT_WRITE);
    div_start  = (state_q == ST_EVAL) && rd_freq_q && !freq_zero;
    out_load   = (state_q == ST_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
    end else if (cfg_valid_i) begin
      prescale_q <= cfg_data_i;
    end
  end

  // Update the sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_seq_q <= 1'b0;
      playing_q <= 1'b0;
      start_q   <= '0;
      length_q  <= '0;
      loop_q    <= 1'b0;
      prio_q    <= PRIO_IDLE;
      index_q   <= '0;
      elapsed_q <= '0;
      reload_q  <= '0;
      compare_q <= '0;
      update_q  <= 1'b0;
      rd_addr_q <= '0;
      rd_freq_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            update_q <= (in_data_i.action == ACT_TICK);
            unique case (in_data_i.action)
              ACT_TICK: begin
                if (!has_seq_q) begin
                  compare_q <= '0;
                end else if (!playing_q) begin
                  index_q   <= '0;
                  elapsed_q <= '0;
                  playing_q <= 1'b1;
                  rd_addr_q <= start_q;
                  rd_freq_q <= 1'b1;
                end else begin
                  elapsed_q <= elapsed_q + 16'd1;
                  rd_addr_q <= start_q + index_q[AddrW-1:0];
                  rd_freq_q <= 1'b0;
                end
              end
              ACT_PLAY: begin
                if (!play_ignore) begin
                  has_seq_q <= 1'b1;
                  start_q   <= in_data_i.seq_start;
                  length_q  <= in_data_i.seq_length;
                  loop_q    <= in_data_i.loop_mode;
                  prio_q    <= in_data_i.priority_req;
                  playing_q <= 1'b0;
                  index_q   <= '0;
                  elapsed_q <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_EVAL: begin
          if (rd_freq_q) begin
            if (freq_zero) begin
              compare_q <= '0;
            end
          end else if (!dur_hit) begin
            update_q <= 1'b0;
          end else begin
            index_q   <= index_next;
            elapsed_q <= '0;
            if (seq_end) begin
              playing_q <= 1'b0;
              if (loop_q) begin
                update_q <= 1'b0;
              end else begin
                has_seq_q <= 1'b0;
                prio_q    <= PRIO_IDLE;
                compare_q <= '0;
              end
            end else begin
              rd_addr_q <= start_q + index_next[AddrW-1:0];
              rd_freq_q <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            reload_q  <= div_reload;
            compare_q <= div_compare;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the result register and drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.reload_value  <= reload_q;
      out_data_q.compare_value <= compare_q;
      out_data_q.tone_update   <= update_q;
      out_data_q.active        <= has_seq_q;
      out_data_q.note_position <= index_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign note_wdata.freq     = in_data_i.note_freq;
  assign note_wdata.duration = in_data_i.note_duration;

  pts_note_mem u_note_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (in_data_i.note_addr),
    .wdata_i (note_wdata),
    .raddr_i (rd_addr_q),
    .rdata_o (note_rdata)
  );

  pts_tone_div u_tone_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .freq_i     (note_rdata.freq),
    .prescale_i (prescale_q),
    .done_o     (div_done),
    .reload_o   (div_reload),
    .compare_o  (div_compare)
  );

endmodule

`default_nettype wire
